>>> rtl/wqu_pkg.sv
// ----------------------------------------------------------------------------
// wqu_pkg
// types and codes shared by the wait queue cells, channels and top level
// ----------------------------------------------------------------------------
package wqu_pkg;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	localparam logic MODE_FIFO = 1'b0;
	localparam logic MODE_EDF  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  entry_id;
		logic [31:0] entry_key;
	} req_t;

	typedef struct packed {
		logic [7:0] popped_id;
		logic       popped_valid;
		logic [1:0] status;
		logic [4:0] occupancy;
	} rsp_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic        push;
		logic        pop;
		logic        mode;
		logic [7:0]  new_id;
		logic [31:0] new_key;
	} cell_ctl_t;

endpackage

>>> rtl/wqu_stream_if.sv
// ----------------------------------------------------------------------------
// wqu_stream_if
// valid/ready channel carrying one beat of type T
// ----------------------------------------------------------------------------
interface wqu_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wqu_cell.sv
// ----------------------------------------------------------------------------
// wqu_cell
// one queue slot: holds an id and key, shifts towards head on pop and
// towards tail behind the insertion point on push
// ----------------------------------------------------------------------------
module wqu_cell (
	input  logic               clk,
	input  wqu_pkg::cell_ctl_t ctl,
	input  logic               occupied,
	input  logic               at_tail,
	input  logic               taken_in,
	output logic               taken_out,
	input  logic [7:0]         left_id,
	input  logic [31:0]        left_key,
	input  logic [7:0]         right_id,
	input  logic [31:0]        right_key,
	output logic [7:0]         id,
	output logic [31:0]        key
);

	logic [7:0]  id_q;
	logic [31:0] key_q;
	logic        greater;
	logic        ins_here;

	assign greater   = occupied && (ctl.mode == wqu_pkg::MODE_EDF) && (key_q > ctl.new_key);
	assign ins_here  = !taken_in && (greater || at_tail);
	assign taken_out = taken_in || ins_here;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (taken_in) begin
				id_q  <= left_id;
				key_q <= left_key;
			end else if (ins_here) begin
				id_q  <= ctl.new_id;
				key_q <= ctl.new_key;
			end
		end else if (ctl.pop) begin
			id_q  <= right_id;
			key_q <= right_key;
		end
	end

	assign id  = id_q;
	assign key = key_q;

endmodule

>>> rtl/fifo_or_edf_wait_queue_unit.sv
// ----------------------------------------------------------------------------
// fifo_or_edf_wait_queue_unit
// bounded wait queue, first-in first-out or earliest key first
// ----------------------------------------------------------------------------
// Requests arrive on req (push with id and key, or pop) and each produces
// exactly one beat on rsp: the popped id with its valid flag, a status code
// and the occupancy after the request. sched_mode is written through
// cfg_we/cfg_wdata, which the user must do only while the queue is quiet;
// the block does not enforce this. 0 appends at the tail, 1 places the entry
// in front of the first held entry with a strictly greater key. The entries
// live in a row of QUEUE_DEPTH cells. On a push every cell compares its key
// with the new one at once and a take signal ripples down the row to mark
// the insertion point; cells behind it take their left neighbour. On a pop
// every cell takes its right neighbour. Responses are registered, and one
// request is accepted per cycle; the insertion ripple through the cell row
// sets the clock period. The response register stays full while rsp is
// stalled and req.ready drops until the beat is taken.
// Reset empties the queue, clears the mode to first-in first-out and drops
// any pending response; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_or_edf_wait_queue_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	wqu_stream_if.sink   req,
	wqu_stream_if.source rsp
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          mode_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_next;
	logic          rsp_valid_q;
	wqu_pkg::rsp_t rsp_q;
	wqu_pkg::rsp_t rsp_next;
	wqu_pkg::cell_ctl_t ctl;

	logic          fire;
	logic          full;
	logic          empty;
	logic          push_ok;
	logic          pop_ok;
	logic [31:0]   occ_wide;

	logic [7:0]            id_w  [QUEUE_DEPTH];
	logic [31:0]           key_w [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0]  taken_w;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign full      = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);
	assign push_ok   = fire && (req.data.req_type == wqu_pkg::REQ_PUSH) && !full;
	assign pop_ok    = fire && (req.data.req_type == wqu_pkg::REQ_POP) && !empty;

	always_comb begin
		ctl.push    = push_ok;
		ctl.pop     = pop_ok;
		ctl.mode    = mode_q;
		ctl.new_id  = req.data.entry_id;
		ctl.new_key = req.data.entry_key;
	end

	assign taken_w[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic [7:0]  lid;
		logic [31:0] lkey;
		logic [7:0]  rid;
		logic [31:0] rkey;

		if (i == 0) begin : g_first
			assign lid  = req.data.entry_id;
			assign lkey = req.data.entry_key;
		end else begin : g_mid_l
			assign lid  = id_w[i-1];
			assign lkey = key_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign rid  = id_w[i];
			assign rkey = key_w[i];
		end else begin : g_mid_r
			assign rid  = id_w[i+1];
			assign rkey = key_w[i+1];
		end

		wqu_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (IDX < cnt_q),
			.at_tail   (IDX == cnt_q),
			.taken_in  (taken_w[i]),
			.taken_out (taken_w[i+1]),
			.left_id   (lid),
			.left_key  (lkey),
			.right_id  (rid),
			.right_key (rkey),
			.id        (id_w[i]),
			.key       (key_w[i])
		);
	end

	always_comb begin
		cnt_next = cnt_q;
		if (push_ok) begin
			cnt_next = cnt_q + CW'(1);
		end else if (pop_ok) begin
			cnt_next = cnt_q - CW'(1);
		end
		occ_wide = 32'(cnt_next);

		rsp_next.popped_id    = pop_ok ? id_w[0] : 8'd0;
		rsp_next.popped_valid = pop_ok;
		rsp_next.occupancy    = occ_wide[4:0];
		if (req.data.req_type == wqu_pkg::REQ_PUSH) begin
			rsp_next.status = full ? wqu_pkg::ST_FULL : wqu_pkg::ST_OK;
		end else begin
			rsp_next.status = empty ? wqu_pkg::ST_EMPTY : wqu_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= wqu_pkg::MODE_FIFO;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			cnt_q <= cnt_next;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// fill count stays within the row
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("fill count beyond queue depth");

	// an accepted push always finds a slot somewhere in the row
	a_ins_found: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |-> taken_w[QUEUE_DEPTH])
		else $error("push found no insertion cell");

	// pop on an empty queue reports empty with no id
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.data.req_type == wqu_pkg::REQ_POP) && empty |=>
		rsp.valid && (rsp.data.status == wqu_pkg::ST_EMPTY) && !rsp.data.popped_valid)
		else $error("empty pop not flagged");

	// a successful push grows the queue by exactly one
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("push did not grow fill count");

endmodule

>>> test/fifo_or_edf_wait_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_or_edf_wait_queue_checker
// watches the request, response and mode write ports of the wait queue
// ----------------------------------------------------------------------------
// Keeps its own copy of the queue as a list of (id, key) slots. FIFO mode
// appends at the tail, and EDF mode inserts in front of the first slot with a
// strictly greater key. Every accepted request beat queues the response it
// should produce. Every accepted response beat is compared field by field
// with the oldest queued response. The count of responses still owed and the
// count of failures are handed to the testbench top.
// ----------------------------------------------------------------------------
module fifo_or_edf_wait_queue_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          req_valid,
	input  logic          req_ready,
	input  wqu_pkg::req_t req_beat,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  wqu_pkg::rsp_t rsp_beat,
	output int            outstanding,
	output int            failures
);

	typedef struct {
		logic [7:0]  id;
		logic [31:0] key;
	} slot_t;

	slot_t         held[$];
	wqu_pkg::rsp_t owed[$];
	logic          mode;

	function automatic wqu_pkg::rsp_t serve_request(wqu_pkg::req_t r);
		wqu_pkg::rsp_t o;
		slot_t         s;
		int            pos;
		o = '0;
		o.status = wqu_pkg::ST_OK;
		if (r.req_type == wqu_pkg::REQ_PUSH) begin
			if (held.size() >= QUEUE_DEPTH) begin
				o.status = wqu_pkg::ST_FULL;
			end else begin
				s.id = r.entry_id;
				s.key = r.entry_key;
				pos = held.size();
				if (mode == wqu_pkg::MODE_EDF) begin
					for (int i = 0; i < held.size(); i++) begin
						if (held[i].key > r.entry_key) begin
							pos = i;
							break;
						end
					end
				end
				held.insert(pos, s);
			end
		end else begin
			if (held.size() == 0) begin
				o.status = wqu_pkg::ST_EMPTY;
			end else begin
				o.popped_id = held[0].id;
				o.popped_valid = 1'b1;
				void'(held.pop_front());
			end
		end
		o.occupancy = 5'(held.size());
		return o;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		wqu_pkg::rsp_t want;
		if (!arst_n) begin
			held.delete();
			owed.delete();
			mode = wqu_pkg::MODE_FIFO;
			failures = 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (owed.size() == 0) begin
					$display("%0t: response beat expected none actual %h", $time, rsp_beat);
					failures++;
				end else begin
					want = owed.pop_front();
					check_field("popped_id", 32'(want.popped_id), 32'(rsp_beat.popped_id));
					check_field("popped_valid", 32'(want.popped_valid),
						32'(rsp_beat.popped_valid));
					check_field("status", 32'(want.status), 32'(rsp_beat.status));
					check_field("occupancy", 32'(want.occupancy), 32'(rsp_beat.occupancy));
				end
			end
			if (cfg_we)
				mode = cfg_wdata;
			if (req_valid && req_ready)
				owed.push_back(serve_request(req_beat));
			outstanding <= owed.size();
		end
	end

endmodule

>>> test/fifo_or_edf_wait_queue_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_or_edf_wait_queue_unit_test
// stimulus and verdict for the FIFO / EDF wait queue
// ----------------------------------------------------------------------------
// A short directed part covers empty pops, extreme ids and keys, equal keys
// in EDF order and a push into a full queue. Random phases then alternate the
// scheduling mode with different push/pop mixes so the queue fills and
// drains, while both sides insert random idle bursts. The last phase runs
// without idling. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module fifo_or_edf_wait_queue_unit_test;

	localparam int QUEUE_DEPTH = 16;
	localparam int PHASES = 7;
	localparam int PHASE_BEATS = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic calm;
	int   outstanding;
	int   failures;

	wqu_stream_if #(.T(wqu_pkg::req_t)) req ();
	wqu_stream_if #(.T(wqu_pkg::rsp_t)) rsp ();

	fifo_or_edf_wait_queue_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	fifo_or_edf_wait_queue_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_beat   (req.data),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_beat   (rsp.data),
		.outstanding(outstanding),
		.failures   (failures)
	);

	always #10 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// response side: ready runs broken by stall bursts
	initial begin
		int run;
		int hold;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 40);
			hold = $urandom_range(1, 15);
			rsp.ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (!calm && $urandom_range(0, 1) == 1) begin
				rsp.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	task automatic send(input logic kind, input logic [7:0] id, input logic [31:0] key,
			input int gap_pct);
		req.valid <= 1'b1;
		req.data <= wqu_pkg::req_t'{req_type: kind, entry_id: id, entry_key: key};
		do @(posedge clk); while (!req.ready);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_mode(input logic m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 7));
			1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [31:0] edf_keys[QUEUE_DEPTH];
		int          push_pct[PHASES];
		logic        kind;
		edf_keys = '{32'hFFFF_FFFF, 32'h0, 32'd5, 32'd5, 32'd3, 32'hFFFF_FFFF, 32'd5,
			32'h8000_0000, 32'h0, 32'd7, 32'd3, 32'h7FFF_FFFF, 32'd1, 32'd5,
			32'hFFFF_FFFE, 32'd2};
		push_pct = '{70, 35, 55, 80, 25, 50, 60};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = wqu_pkg::MODE_FIFO;
		calm = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first-in first-out after reset: empty pops and extreme fields
		send(wqu_pkg::REQ_POP, 8'hFF, 32'hFFFF_FFFF, 0);
		send(wqu_pkg::REQ_PUSH, 8'h00, 32'h0, 0);
		send(wqu_pkg::REQ_PUSH, 8'hFF, 32'hFFFF_FFFF, 30);
		send(wqu_pkg::REQ_POP, 8'h00, 32'h0, 0);
		send(wqu_pkg::REQ_POP, 8'hFF, 32'hFFFF_FFFF, 30);
		send(wqu_pkg::REQ_POP, 8'h00, 32'h0, 0);

		// earliest key first: ties, extremes, full queue
		set_mode(wqu_pkg::MODE_EDF);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send(wqu_pkg::REQ_PUSH, 8'hA0 + 8'(i), edf_keys[i], 30);
		send(wqu_pkg::REQ_PUSH, 8'h55, 32'd4, 0);
		send(wqu_pkg::REQ_POP, 8'h00, 32'h0, 0);
		send(wqu_pkg::REQ_POP, 8'h00, 32'h0, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_mode(ph % 2 == 0 ? wqu_pkg::MODE_FIFO : wqu_pkg::MODE_EDF);
			if (ph == PHASES - 1)
				calm = 1'b1;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (ph == 3 && n == PHASE_BEATS / 2)
					drain();
				kind = ($urandom_range(0, 99) < push_pct[ph]) ? wqu_pkg::REQ_PUSH
					: wqu_pkg::REQ_POP;
				send(kind, 8'($urandom_range(0, 255)), pick_key(), ph % 3 == 0 ? 0 : 30);
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/wqu_pkg.sv
rtl/wqu_stream_if.sv
rtl/wqu_cell.sv
rtl/fifo_or_edf_wait_queue_unit.sv
test/fifo_or_edf_wait_queue_checker.sv
test/fifo_or_edf_wait_queue_unit_test.sv
